// ===== rtl/core/rwhp_pkg.sv =====
// ----------------------------------------------------------------------------
// rwhp_pkg
// Shared types and constants of the RIFF/WAVE header parser.
// ----------------------------------------------------------------------------
package rwhp_pkg;

    localparam int OFFSET_BITS_DEF = 40;
    localparam int FIXED_BITS      = 192;
    localparam int CFG_IDX_W       = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_STRICT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH  = CFG_IDX_W'(1);

    localparam logic [15:0] DEPTH_RST = 16'd32;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;
    localparam logic [31:0] FMT_MIN  = 32'd16;
    localparam logic [15:0] FMT_PCM  = 16'd1;
    localparam logic [15:0] FMT_EXT  = 16'd65534;

    typedef enum logic [1:0] {
        PH_RIFF,
        PH_CHDR,
        PH_FMT,
        PH_SKIP
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_BAD_TAGS,
        ST_FMT_SMALL,
        ST_BAD_FORMAT,
        ST_BAD_DEPTH,
        ST_NO_FMT,
        ST_TRUNCATED
    } status_t;

    typedef struct packed {
        logic        strict_checks;
        logic [15:0] required_bit_depth;
    } cfg_t;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       end_of_stream;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] riff_size;
        logic [15:0] format_code;
        logic [15:0] channel_count;
        logic [31:0] samples_per_sec;
        logic [31:0] bytes_per_sec;
        logic [15:0] block_align;
        logic [15:0] bits_per_sample;
        logic [31:0] data_size;
    } res_t;

endpackage

// ===== rtl/core/rwhp_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// rwhp_cfg_regs
// Configuration register file: strict checking enable and required depth.
// ----------------------------------------------------------------------------
module rwhp_cfg_regs
    import rwhp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,
    output cfg_t                 cfg
);

    logic        strict_reg, strict_next;
    logic [15:0] depth_reg, depth_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        strict_next = strict_reg;
        depth_next  = depth_reg;
        if (cfg_valid) begin
            if (cfg_index == CFG_STRICT) begin
                strict_next = cfg_data[0];
            end else if (cfg_index == CFG_DEPTH) begin
                depth_next = cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strict_reg <= 1'b1;
            depth_reg  <= DEPTH_RST;
        end else begin
            strict_reg <= strict_next;
            depth_reg  <= depth_next;
        end
    end

    assign cfg.strict_checks      = strict_reg;
    assign cfg.required_bit_depth = depth_reg;

endmodule

// ===== rtl/core/rwhp_in_stage.sv =====
// ----------------------------------------------------------------------------
// rwhp_in_stage
// Input register: holds one byte transaction until the parser takes it.
// ----------------------------------------------------------------------------
module rwhp_in_stage
    import rwhp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  logic [7:0] s_tdata,
    input  logic     s_tlast,
    input  logic     take,
    output logic     item_valid,
    output in_item_t item
);

    logic     vld_reg, vld_next;
    in_item_t item_reg;

    assign s_tready = !vld_reg || take;

    always_comb begin
        vld_next = vld_reg;
        if (s_tready) begin
            vld_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.file_byte     <= s_tdata;
            item_reg.end_of_stream <= s_tlast;
        end
    end

    assign item_valid = vld_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/core/rwhp_parser.sv =====
// ----------------------------------------------------------------------------
// rwhp_parser
// Per-byte header walk: tag and size checks, fmt capture, chunk skipping.
// ----------------------------------------------------------------------------
module rwhp_parser
    import rwhp_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   fire,
    input  in_item_t               item,
    input  cfg_t                   cfg,
    output logic                   res_valid,
    output res_t                   res,
    output logic [OFFSET_BITS-1:0] res_offset
);

    phase_t                 phase_reg, phase_next;
    logic [3:0]             cnt_reg, cnt_next;
    logic [31:0]            tag_reg, tag_next;
    logic [31:0]            len_reg, len_next;
    logic [32:0]            skip_reg, skip_next;
    logic                   fmt_seen_reg, fmt_seen_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic                   finished_reg, finished_next;
    logic [31:0]            riff_size_reg, riff_size_next;
    logic [63:0]            fmt_lo_reg, fmt_lo_next;
    logic [63:0]            fmt_hi_reg, fmt_hi_next;

    logic [7:0]             b;
    logic                   active;
    logic                   restart;
    logic [31:0]            tag_shift;
    logic [31:0]            len_shift;
    logic [32:0]            skip_fmt;
    logic [OFFSET_BITS-1:0] pos_inc;
    logic                   st_hit;
    status_t                st_code;

    assign b         = item.file_byte;
    assign active    = fire && !finished_reg;
    assign restart   = fire && finished_reg && item.end_of_stream;
    assign tag_shift = {tag_reg[23:0], b};
    assign len_shift = {b, len_reg[31:8]};
    assign pos_inc   = (&pos_reg) ? pos_reg : pos_reg + 1'b1;
    assign skip_fmt  = (len_reg > FMT_MIN)
                     ? {1'b0, len_reg} - {1'b0, FMT_MIN} + {32'd0, len_reg[0]}
                     : 33'd0;

    // captured header and fmt bytes
    always_comb begin
        riff_size_next = riff_size_reg;
        fmt_lo_next    = fmt_lo_reg;
        fmt_hi_next    = fmt_hi_reg;
        if (restart) begin
            riff_size_next = '0;
            fmt_lo_next    = '0;
            fmt_hi_next    = '0;
        end else if (active) begin
            unique case (phase_reg)
                PH_RIFF: begin
                    if (cnt_reg[3:2] == 2'b01) begin
                        riff_size_next[{cnt_reg[1:0], 3'b000} +: 8] = b;
                    end
                end
                PH_FMT: begin
                    if (!cnt_reg[3]) begin
                        fmt_lo_next[{cnt_reg[2:0], 3'b000} +: 8] = b;
                    end else begin
                        fmt_hi_next[{cnt_reg[2:0], 3'b000} +: 8] = b;
                    end
                end
                PH_CHDR, PH_SKIP: begin
                end
            endcase
        end
    end

    // result detection
    always_comb begin
        st_hit  = 1'b0;
        st_code = ST_OK;
        if (active) begin
            unique case (phase_reg)
                PH_RIFF: begin
                    if (cnt_reg >= 4'd11 && cfg.strict_checks
                        && (tag_shift != TAG_WAVE || len_reg != TAG_RIFF)) begin
                        st_hit  = 1'b1;
                        st_code = ST_BAD_TAGS;
                    end
                end
                PH_CHDR: begin
                    if (cnt_reg >= 4'd7) begin
                        if (tag_reg == TAG_FMT) begin
                            if (cfg.strict_checks && len_shift < FMT_MIN) begin
                                st_hit  = 1'b1;
                                st_code = ST_FMT_SMALL;
                            end
                        end else if (tag_reg == TAG_DATA) begin
                            st_hit  = 1'b1;
                            st_code = (cfg.strict_checks && !fmt_seen_reg) ? ST_NO_FMT : ST_OK;
                        end
                    end
                end
                PH_FMT: begin
                    if (cnt_reg >= 4'd15 && cfg.strict_checks) begin
                        if (fmt_lo_reg[15:0] != FMT_PCM && fmt_lo_reg[15:0] != FMT_EXT) begin
                            st_hit  = 1'b1;
                            st_code = ST_BAD_FORMAT;
                        end else if (fmt_hi_next[63:48] != cfg.required_bit_depth) begin
                            st_hit  = 1'b1;
                            st_code = ST_BAD_DEPTH;
                        end
                    end
                end
                PH_SKIP: begin
                end
            endcase
            if (!st_hit && item.end_of_stream) begin
                st_hit  = 1'b1;
                st_code = ST_TRUNCATED;
            end
        end
    end

    // next parse state
    always_comb begin
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        tag_next      = tag_reg;
        len_next      = len_reg;
        skip_next     = skip_reg;
        fmt_seen_next = fmt_seen_reg;
        pos_next      = pos_reg;
        finished_next = finished_reg;
        if (restart) begin
            phase_next    = PH_RIFF;
            cnt_next      = '0;
            tag_next      = '0;
            len_next      = '0;
            skip_next     = '0;
            fmt_seen_next = 1'b0;
            pos_next      = '0;
            finished_next = 1'b0;
        end else if (active) begin
            pos_next = pos_inc;
            unique case (phase_reg)
                PH_RIFF: begin
                    if (cnt_reg < 4'd4 || cnt_reg >= 4'd8) begin
                        tag_next = tag_shift;
                    end
                    if (cnt_reg == 4'd3) begin
                        len_next = tag_shift;
                    end
                    if (cnt_reg >= 4'd11) begin
                        cnt_next   = '0;
                        phase_next = PH_CHDR;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                PH_CHDR: begin
                    if (cnt_reg < 4'd4) begin
                        tag_next = tag_shift;
                    end else begin
                        len_next = len_shift;
                    end
                    if (cnt_reg >= 4'd7) begin
                        cnt_next = '0;
                        if (tag_reg == TAG_FMT) begin
                            phase_next = PH_FMT;
                        end else if (tag_reg != TAG_DATA) begin
                            skip_next  = {1'b0, len_shift} + {32'd0, len_shift[0]};
                            phase_next = (len_shift == 32'd0) ? PH_CHDR : PH_SKIP;
                        end
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                PH_FMT: begin
                    if (cnt_reg >= 4'd15) begin
                        cnt_next      = '0;
                        fmt_seen_next = 1'b1;
                        skip_next     = skip_fmt;
                        phase_next    = (skip_fmt == 33'd0) ? PH_CHDR : PH_SKIP;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                PH_SKIP: begin
                    if (skip_reg != 33'd0) begin
                        skip_next = skip_reg - 1'b1;
                    end
                    if (skip_reg <= 33'd1) begin
                        phase_next = PH_CHDR;
                        cnt_next   = '0;
                    end
                end
            endcase
            if (st_hit) begin
                finished_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_RIFF;
            cnt_reg       <= '0;
            tag_reg       <= '0;
            len_reg       <= '0;
            skip_reg      <= '0;
            fmt_seen_reg  <= 1'b0;
            pos_reg       <= '0;
            finished_reg  <= 1'b0;
            riff_size_reg <= '0;
            fmt_lo_reg    <= '0;
            fmt_hi_reg    <= '0;
        end else begin
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            tag_reg       <= tag_next;
            len_reg       <= len_next;
            skip_reg      <= skip_next;
            fmt_seen_reg  <= fmt_seen_next;
            pos_reg       <= pos_next;
            finished_reg  <= finished_next;
            riff_size_reg <= riff_size_next;
            fmt_lo_reg    <= fmt_lo_next;
            fmt_hi_reg    <= fmt_hi_next;
        end
    end

    assign res_valid           = st_hit;
    assign res.status          = st_code;
    assign res.riff_size       = riff_size_next;
    assign res.format_code     = fmt_lo_next[15:0];
    assign res.channel_count   = fmt_lo_next[31:16];
    assign res.samples_per_sec = fmt_lo_next[63:32];
    assign res.bytes_per_sec   = fmt_hi_next[31:0];
    assign res.block_align     = fmt_hi_next[47:32];
    assign res.bits_per_sample = fmt_hi_next[63:48];
    assign res.data_size       = (st_code == ST_OK) ? len_shift : 32'd0;
    assign res_offset          = (st_code == ST_OK) ? pos_inc : '0;

    a_finish_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |=> finished_reg)
        else $error("parser not finished after a result");

    a_quiet_when_finished: assert property (@(posedge aclk) disable iff (!aresetn)
        finished_reg |-> !res_valid)
        else $error("result produced after finishing");

    a_skip_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_SKIP |-> skip_reg != 33'd0)
        else $error("skip phase with nothing left to skip");

    a_ok_has_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && st_code == ST_OK |-> res_offset != '0 && fmt_seen_reg | !cfg.strict_checks)
        else $error("ok result without offset or fmt");

endmodule

// ===== rtl/core/rwhp_out_stage.sv =====
// ----------------------------------------------------------------------------
// rwhp_out_stage
// Result register: holds one result transaction until the sink takes it.
// ----------------------------------------------------------------------------
module rwhp_out_stage
    import rwhp_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  res_t                   res,
    input  logic [OFFSET_BITS-1:0] res_offset,
    output logic                   room,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output res_t                   out_res,
    output logic [OFFSET_BITS-1:0] out_offset
);

    logic                   vld_reg, vld_next;
    res_t                   res_reg;
    logic [OFFSET_BITS-1:0] offset_reg;

    assign room = !vld_reg || m_tready;

    always_comb begin
        vld_next = vld_reg;
        if (load) begin
            vld_next = 1'b1;
        end else if (m_tready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg    <= res;
            offset_reg <= res_offset;
        end
    end

    assign m_tvalid   = vld_reg;
    assign out_res    = res_reg;
    assign out_offset = offset_reg;

endmodule

// ===== rtl/core/riff_wave_header_parser.sv =====
// ----------------------------------------------------------------------------
// riff_wave_header_parser
// Byte-stream RIFF/WAVE header parser giving one status and format result.
// ----------------------------------------------------------------------------
// path: an accepted byte is registered at the input, parsed when the output
//   stage has room, and its result is then registered and shown on m_tvalid
// throughput: one byte per cycle (single parse stage) while output has room
// reset: synchronous active-low aresetn clears parse state, restores
//   strict checking and a required depth of 32; no clearing pass
module riff_wave_header_parser
    import rwhp_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    localparam int TDATA_W    = ((FIXED_BITS + OFFSET_BITS + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // file_byte
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // riff_size, format_code, channel_count, samples_per_sec, bytes_per_sec,
    // block_align, bits_per_sample, data_size, payload_offset
    output logic [TDATA_W-1:0]   m_tdata,
    output logic [2:0]           m_tuser,   // status
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    cfg_t                   cfg;
    in_item_t               item;
    logic                   item_valid;
    logic                   room;
    logic                   fire;
    logic                   res_valid;
    res_t                   res;
    logic [OFFSET_BITS-1:0] res_offset;
    res_t                   out_res;
    logic [OFFSET_BITS-1:0] out_offset;

    assign fire = item_valid && room;

    rwhp_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rwhp_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    rwhp_parser #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (fire),
        .item       (item),
        .cfg        (cfg),
        .res_valid  (res_valid),
        .res        (res),
        .res_offset (res_offset)
    );

    rwhp_out_stage #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (fire && res_valid),
        .res        (res),
        .res_offset (res_offset),
        .room       (room),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .out_res    (out_res),
        .out_offset (out_offset)
    );

    always_comb begin
        m_tdata          = '0;
        m_tdata[31:0]    = out_res.riff_size;
        m_tdata[47:32]   = out_res.format_code;
        m_tdata[63:48]   = out_res.channel_count;
        m_tdata[95:64]   = out_res.samples_per_sec;
        m_tdata[127:96]  = out_res.bytes_per_sec;
        m_tdata[143:128] = out_res.block_align;
        m_tdata[159:144] = out_res.bits_per_sample;
        m_tdata[191:160] = out_res.data_size;
        m_tdata[FIXED_BITS +: OFFSET_BITS] = out_offset;
    end

    assign m_tuser = out_res.status;

endmodule
